FILE: hdl/ppdc_pkg.sv
// ----------------------------------------------------------------------------
// ppdc_pkg
// Shared types, constants and helpers of the pixel pair compare block.
// ----------------------------------------------------------------------------
package ppdc_pkg;

    // Q16 luma weights, sum is 65536 so gray never exceeds 255
    localparam logic [15:0] PPDC_W_BYTE0 = 16'd13933;
    localparam logic [15:0] PPDC_W_BYTE1 = 16'd46871;
    localparam logic [15:0] PPDC_W_BYTE2 = 16'd4732;

    // Depth of the queue between front and back
    localparam int PPDC_QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int           PPDC_CFG_IDX_W   = 2;
    localparam int           PPDC_CFG_DATA_W  = 32;
    localparam logic [1:0]   CFG_CHAN_TOL     = 2'd0;
    localparam logic [1:0]   CFG_PIX_TOL      = 2'd1;
    localparam logic [1:0]   CFG_GRAY_MODE    = 2'd2;

    localparam logic [31:0]  PPDC_COUNT_MAX   = 32'hFFFF_FFFF;

    // One classified item, handed from front to back
    typedef struct packed {
        logic [7:0] a_byte0;
        logic [7:0] a_byte1;
        logic [7:0] b_byte2;
        logic [7:0] gray_a;
        logic [7:0] gray_b;
        logic       differs;
        logic       line_end;   // line mark or page mark
        logic       page_end;
    } t_work;

    // Truncated Q16 gray of one pixel
    function automatic logic [7:0] gray_of(input logic [7:0] c0,
                                           input logic [7:0] c1,
                                           input logic [7:0] c2);
        logic [23:0] sum;
        sum = 24'(PPDC_W_BYTE0) * 24'(c0) + 24'(PPDC_W_BYTE1) * 24'(c1)
            + 24'(PPDC_W_BYTE2) * 24'(c2);
        return sum[23:16];
    endfunction

    // Absolute byte difference above tolerance
    function automatic logic byte_differs(input logic [7:0] x,
                                          input logic [7:0] y,
                                          input logic [7:0] tol);
        logic [7:0] d;
        d = (x > y) ? (x - y) : (y - x);
        return d > tol;
    endfunction

endpackage

FILE: hdl/pixel_pair_diff_compare.sv
// ----------------------------------------------------------------------------
// pixel_pair_diff_compare
// Compares co-located pixels of two page images and blends a view pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one pixel pair per item: tdata holds image A
//   bytes 0..2 then image B bytes 0..2, tuser marks the last pixel of a line,
//   tlast the last pixel of the page (which also ends the line).
//   Master stream returns one result per item: blended bytes, the pixel,
//   line and page difference flags and the running differing count.
//   Configuration writes (channel tolerance, pixel tolerance, gray mode) go
//   through i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight.
// Timing:
//   A result passes through the queue, then the output register. One item
//   per clock is sustained while results are taken; the page counter and
//   line flag update in the back end once per popped item, setting that rate.
// Reset and stall:
//   Synchronous reset clears the registers, counter, flag and queue.
//   When the receiver stalls, the result holds, the two-entry queue fills
//   and s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
module pixel_pair_diff_compare import ppdc_pkg::*; #(
    parameter int QUEUE_DEPTH = PPDC_QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // a_byte0, a_byte1, a_byte2, b_byte0, b_byte1, b_byte2
    input  logic [47:0]                s_axis_tdata,
    // line_last
    input  logic [0:0]                 s_axis_tuser,
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // out_byte0, out_byte1, out_byte2, pixel_differs, line_differs,
    // page_differs, differing_count, zero fill
    output logic [63:0]                m_axis_tdata,
    input  logic                       i_cfg_we,
    input  logic [PPDC_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [PPDC_CFG_DATA_W-1:0] i_cfg_data
);

    logic [7:0]  r_chan_tol;
    logic [31:0] r_pix_tol;
    logic        r_gray_mode;
    t_work       front_work, head_work;
    logic        q_full, q_empty, q_pop;

    // Configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_tol  <= '0;
            r_pix_tol   <= '0;
            r_gray_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHAN_TOL:  r_chan_tol  <= i_cfg_data[7:0];
                CFG_PIX_TOL:   r_pix_tol   <= i_cfg_data[31:0];
                CFG_GRAY_MODE: r_gray_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = ~q_full;

    ppdc_front u_front (
        .i_pixels    (s_axis_tdata),
        .i_line_last (s_axis_tuser[0]),
        .i_page_last (s_axis_tlast),
        .i_chan_tol  (r_chan_tol),
        .o_work      (front_work)
    );

    ppdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_work  (front_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (head_work)
    );

    ppdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_tol   (r_pix_tol),
        .i_gray_mode (r_gray_mode),
        .i_empty     (q_empty),
        .i_head      (head_work),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

endmodule

FILE: hdl/ppdc_front.sv
// ----------------------------------------------------------------------------
// ppdc_front
// Classifies one pixel pair: channel compare against tolerance, gray of both.
// ----------------------------------------------------------------------------
module ppdc_front import ppdc_pkg::*; (
    input  logic [47:0] i_pixels,     // a0, a1, a2, b0, b1, b2 from bit 0 up
    input  logic        i_line_last,
    input  logic        i_page_last,
    input  logic [7:0]  i_chan_tol,
    output t_work       o_work
);

    logic [7:0] a0, a1, a2, b0, b1, b2;

    // Split the pixel pair
    assign a0 = i_pixels[7:0];
    assign a1 = i_pixels[15:8];
    assign a2 = i_pixels[23:16];
    assign b0 = i_pixels[31:24];
    assign b1 = i_pixels[39:32];
    assign b2 = i_pixels[47:40];

    // Classify and precompute gray
    always_comb begin
        o_work.a_byte0  = a0;
        o_work.a_byte1  = a1;
        o_work.b_byte2  = b2;
        o_work.gray_a   = gray_of(a0, a1, a2);
        o_work.gray_b   = gray_of(b0, b1, b2);
        o_work.differs  = byte_differs(a0, b0, i_chan_tol)
                        | byte_differs(a1, b1, i_chan_tol)
                        | byte_differs(a2, b2, i_chan_tol);
        o_work.line_end = i_line_last | i_page_last;
        o_work.page_end = i_page_last;
    end

endmodule

FILE: hdl/ppdc_queue.sv
// ----------------------------------------------------------------------------
// ppdc_queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module ppdc_queue import ppdc_pkg::*; #(
    parameter int DEPTH = PPDC_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_work o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

FILE: hdl/ppdc_back.sv
// ----------------------------------------------------------------------------
// ppdc_back
// Counts differing pixels, tracks the line flag and builds the result item.
// ----------------------------------------------------------------------------
module ppdc_back import ppdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_pix_tol,
    input  logic        i_gray_mode,
    input  logic        i_empty,
    input  t_work       i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_data
);

    logic [31:0] r_count, n_count;
    logic        r_line_flag, n_line_flag;
    logic        r_valid;
    logic [63:0] r_data, n_data;
    logic        load;
    logic [31:0] cnt_inc;
    logic        flag_now;
    logic        ldiff, pdiff;
    logic [8:0]  gray_sum;
    logic [7:0]  ob0, ob1, ob2;

    // Take the next item when the output register is free
    assign load  = ~r_valid | i_ready;
    assign o_pop = load & ~i_empty;

    // Update page count and line flag, then blend
    always_comb begin
        cnt_inc  = (i_head.differs && r_count != PPDC_COUNT_MAX) ?
                   r_count + 32'd1 : r_count;
        flag_now = r_line_flag | i_head.differs;
        ldiff    = i_head.line_end & flag_now;
        pdiff    = i_head.page_end & (cnt_inc > i_pix_tol);
        gray_sum = {1'b0, i_head.gray_a} + {1'b0, i_head.gray_b};
        if (i_gray_mode) begin
            ob0 = i_head.gray_b;
            ob1 = gray_sum[8:1];
            ob2 = i_head.gray_a;
        end else begin
            ob0 = i_head.a_byte0;
            ob1 = i_head.a_byte1;
            ob2 = i_head.b_byte2;
        end
        n_count     = i_head.page_end ? '0 : cnt_inc;
        n_line_flag = i_head.line_end ? 1'b0 : flag_now;
        n_data      = {5'd0, cnt_inc, pdiff, ldiff, i_head.differs, ob2, ob1, ob0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_line_flag <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count     <= n_count;
                r_line_flag <= n_line_flag;
            end
            if (load) begin
                r_valid <= ~i_empty;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/ppdc_checker.sv
// ----------------------------------------------------------------------------
// ppdc_checker
// Port-level checks of the pixel pair compare block, bound to the top level.
// ----------------------------------------------------------------------------
module ppdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    // Hold a stalled result
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A differing pixel is always counted
    a_pixel_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[58:27] != 32'd0)
        else $error("differing pixel with zero count");

    // A differing page needs a count above the tolerance, so never zero
    a_page_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[58:27] != 32'd0)
        else $error("page differs with zero count");

endmodule

bind pixel_pair_diff_compare ppdc_checker u_ppdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
